// ===== sv/cscq_pkg.sv =====
// Shared types and constants for the column store count query block.
// Holds the request and response beat layouts and the controller/datapath links.
// No dependencies.
package cscq_pkg;

   localparam int CSCQ_DEPTH = 1024;
   localparam int CMD_W      = 3;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 10;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 11;

   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_EQ     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GT     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LT     = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic signed [VALUE_W-1:0] operand_value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0]        match_count;
   } rsp_type;

   // Controller to datapath strobes.
   typedef struct packed {
      logic load;
      logic decode;
      logic rd_capture;
      logic scan_step;
      logic push;
   } ctl_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             in_range;
      logic             empty;
      logic             scan_last;
      logic             out_free;
   } stat_type;

endpackage

// ===== sv/cscq_dpath.sv =====
// Datapath of the column store count query block: value memory, fill count,
// scan index, match counter and response register. Depends on cscq_pkg.
module cscq_dpath import cscq_pkg::*; #(
   parameter int DEPTH = CSCQ_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  ctl_type  ctl,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = (FW > POS_W) ? FW : POS_W;
   localparam logic [FW-1:0] FULL_COUNT = FW'(DEPTH);

   logic [CMD_W-1:0]          cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] opv_ff, opv_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [FW-1:0]             fill_ff, fill_in;
   logic [FW-1:0]             idx_ff, idx_in;
   rsp_type                   res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] mem_rd_ff;

   logic          full;
   logic          hit;
   logic          wen;
   logic [AW-1:0] raddr;

   assign full = (fill_ff == FULL_COUNT);
   assign wen  = ctl.decode && (cmd_ff == CMD_APPEND) && !full;
   assign raddr = (cmd_ff == CMD_READ) ? AW'(pos_ff) : AW'(idx_ff);

   always_comb begin
      case (cmd_ff)
         CMD_EQ:  hit = ($signed(mem_rd_ff) == opv_ff);
         CMD_GT:  hit = ($signed(mem_rd_ff) > opv_ff);
         default: hit = ($signed(mem_rd_ff) < opv_ff);
      endcase
   end

   assign stat.command   = cmd_ff;
   assign stat.in_range  = (CW'(pos_ff) < CW'(fill_ff));
   assign stat.empty     = (fill_ff == '0);
   assign stat.scan_last = (idx_ff == fill_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd_in       = cmd_ff;
      opv_in       = opv_ff;
      pos_in       = pos_ff;
      fill_in      = wen ? fill_ff + FW'(1) : fill_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (ctl.load) begin
         cmd_in = req_data.command;
         opv_in = req_data.operand_value;
         pos_in = req_data.position;
         idx_in = '0;
      end

      if (ctl.decode || ctl.scan_step) begin
         idx_in = idx_ff + FW'(1);
      end

      if (ctl.decode) begin
         res_in = '0;
         case (cmd_ff)
            CMD_APPEND: begin
               if (full) begin
                  res_in.status = ST_FULL;
               end
            end
            CMD_READ: begin
               if (!stat.in_range) begin
                  res_in.status     = ST_RANGE;
                  res_in.read_value = -32'sd1;
               end
            end
            default: ;
         endcase
      end

      if (ctl.rd_capture) begin
         res_in.read_value = $signed(mem_rd_ff);
      end

      // The sum saturates at the top of the count field.
      if (ctl.scan_step && hit && (res_ff.match_count != COUNT_MAX)) begin
         res_in.match_count = res_ff.match_count + COUNT_W'(1);
      end

      if (ctl.push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      opv_ff      <= opv_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[AW'(fill_ff)] <= opv_ff;
      end
      mem_rd_ff <= mem_ff[raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/cscq_ctrl.sv =====
// Controller state machine of the column store count query block.
// Sequences decode, memory read and scan steps. Depends on cscq_pkg.
module cscq_ctrl import cscq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctl_type  ctl
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_RDWAIT = 5'b00100,
      S_SCAN   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctl       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.decode = 1'b1;
            case (stat.command)
               CMD_READ: state_in = stat.in_range ? S_RDWAIT : S_FINISH;
               CMD_EQ, CMD_GT, CMD_LT: state_in = stat.empty ? S_FINISH : S_SCAN;
               default: state_in = S_FINISH;
            endcase
         end
         S_RDWAIT: begin
            ctl.rd_capture = 1'b1;
            state_in       = S_FINISH;
         end
         S_SCAN: begin
            ctl.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               ctl.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/column_store_count_query_top.sv =====
// Column store count query: append, out-of-range read and unused commands finish straight
// after decode, an in-range read waits for its memory read, and a count scans the filled
// entries, one memory entry scanned per cycle. One command is in flight at a time; the next
// request beat is taken the cycle after the response is loaded, and a result may wait on a
// still-held response beat. Reset clears the fill count and control state; the memory is
// not cleared and needs no clearing.
module column_store_count_query_top import cscq_pkg::*; #(
   parameter int DEPTH = CSCQ_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // The controller only steers; all state that holds column data lives in the
   // datapath. The two talk through one strobe struct and one status struct.
   ctl_type  ctl;
   stat_type stat;

   cscq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // The datapath holds the response register, so a finished beat can wait on
   // rsp_ready while the controller goes back to taking the next request.
   cscq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // An accepted request beat is always decoded in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ctl.decode)
      else $error("request beat not followed by decode");

   // A result is only loaded when the response register can take it.
   assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> stat.out_free)
      else $error("response loaded while previous beat still pending");

   // An out-of-range read always reports all ones as its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_RANGE)) |-> (rsp_data.read_value == -32'sd1))
      else $error("out-of-range read with wrong value");

endmodule

// ===== sim/column_store_count_query_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for column_store_count_query_top. It keeps its own copy of the
// column and fill count, works out every response from it or from the directed table,
// and compares the response beats in order. Depends on cscq_pkg and the top-level RTL.
module column_store_count_query_top_test;
   import cscq_pkg::*;

   localparam int DEPTH          = CSCQ_DEPTH;
   localparam int RANDOM_BEATS   = 140;        // random beats in each idling phase
   localparam int HOLD_CYCLES    = 400;        // long receiver hold-off
   localparam int SETTLE_CYCLES  = DEPTH + 8;  // longest scan plus a margin
   localparam int REPORT_LIMIT   = 10;

   // Command codes that the block leaves unused.
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;
   localparam logic [CMD_W-1:0] SPARE_CODES [3] = '{CMD_SPARE_A, CMD_SPARE_B, CMD_SPARE_C};

   localparam logic signed [VALUE_W-1:0] VAL_MIN   = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX   = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] READ_MISS = -32'sd1;
   localparam logic signed [VALUE_W-1:0] EDGE_VALUES [5] = '{VAL_MIN, VAL_MAX, 0, -1, 1};

   // Idling phases: none, sender idle, receiver stalling, both.
   localparam int SEND_IDLE  [4] = '{0, 53, 0, 32};
   localparam int RECV_STALL [4] = '{0, 0, 53, 32};

   localparam rsp_type RSP_DONE  = '{ST_OK, 32'sd0, 11'd0};
   localparam rsp_type RSP_RANGE = '{ST_RANGE, READ_MISS, 11'd0};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // The testbench's copy of the column. Only entries below mirror_fill are ever used.
   logic signed [VALUE_W-1:0] column_mirror [DEPTH];
   int                        mirror_fill = 0;

   // Responses still owed by the block, oldest first.
   rsp_type pending_answers [$];

   int   mismatches    = 0;
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   logic receiver_held = 1'b0;
   event hold_off_start;

   // One row of the directed table. Where fixed is set, want is the response read off
   // the command at a glance; otherwise the response comes from column_answer.
   typedef struct {
      req_type beat;
      bit      fixed;
      rsp_type want;
   } probe_row_type;

   // The directed table starts on an empty column, builds a short one with the extreme
   // values and duplicates, and then reads and counts against it.
   probe_row_type probe_rows [25] = '{
      '{'{CMD_READ,    32'sd0,    10'd0},    1'b1, RSP_RANGE},
      '{'{CMD_EQ,      32'sd0,    10'd0},    1'b1, RSP_DONE},
      '{'{CMD_GT,      VAL_MIN,   10'd1023}, 1'b1, RSP_DONE},
      '{'{CMD_LT,      VAL_MAX,   10'd0},    1'b1, RSP_DONE},
      '{'{CMD_SPARE_A, VAL_MAX,   10'd1023}, 1'b1, RSP_DONE},
      '{'{CMD_APPEND,  VAL_MIN,   10'd1023}, 1'b1, RSP_DONE},
      '{'{CMD_APPEND,  VAL_MAX,   10'd0},    1'b1, RSP_DONE},
      '{'{CMD_APPEND,  32'sd0,    10'd512},  1'b1, RSP_DONE},
      '{'{CMD_APPEND,  -32'sd1,   10'd0},    1'b1, RSP_DONE},
      '{'{CMD_APPEND,  32'sd1,    10'd0},    1'b1, RSP_DONE},
      '{'{CMD_APPEND,  -32'sd1,   10'd0},    1'b0, RSP_DONE},
      '{'{CMD_READ,    32'sd0,    10'd0},    1'b1, '{ST_OK, VAL_MIN, 11'd0}},
      '{'{CMD_READ,    VAL_MAX,   10'd1},    1'b1, '{ST_OK, VAL_MAX, 11'd0}},
      '{'{CMD_READ,    32'sd0,    10'd5},    1'b0, RSP_DONE},
      '{'{CMD_READ,    VAL_MIN,   10'd6},    1'b1, RSP_RANGE},
      '{'{CMD_READ,    32'sd0,    10'd1023}, 1'b1, RSP_RANGE},
      '{'{CMD_EQ,      -32'sd1,   10'd0},    1'b0, RSP_DONE},
      '{'{CMD_GT,      VAL_MIN,   10'd0},    1'b0, RSP_DONE},
      '{'{CMD_LT,      VAL_MAX,   10'd0},    1'b0, RSP_DONE},
      '{'{CMD_GT,      VAL_MAX,   10'd0},    1'b0, RSP_DONE},
      '{'{CMD_LT,      VAL_MIN,   10'd0},    1'b0, RSP_DONE},
      '{'{CMD_GT,      32'sd0,    10'd0},    1'b0, RSP_DONE},
      '{'{CMD_LT,      32'sd0,    10'd0},    1'b0, RSP_DONE},
      '{'{CMD_SPARE_B, VAL_MIN,   10'd0},    1'b1, RSP_DONE},
      '{'{CMD_SPARE_C, -32'sd1,   10'd512},  1'b1, RSP_DONE}
   };

   column_store_count_query_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Applies one command to the column copy and returns the response it must produce.
   // Counts compare as signed words and saturate at the width of the count field.
   function automatic rsp_type column_answer(input req_type beat);
      rsp_type     answer;
      int unsigned hits;
      bit          hit;
      answer = RSP_DONE;
      hits   = 0;
      case (beat.command)
         CMD_APPEND: begin
            if (mirror_fill >= DEPTH) begin
               answer.status = ST_FULL;
            end else begin
               column_mirror[mirror_fill] = beat.operand_value;
               mirror_fill++;
            end
         end
         CMD_READ: begin
            if (int'(beat.position) < mirror_fill) begin
               answer.read_value = column_mirror[beat.position];
            end else begin
               answer = RSP_RANGE;
            end
         end
         CMD_EQ, CMD_GT, CMD_LT: begin
            for (int i = 0; i < mirror_fill; i++) begin
               case (beat.command)
                  CMD_EQ:  hit = column_mirror[i] == beat.operand_value;
                  CMD_GT:  hit = $signed(column_mirror[i]) > $signed(beat.operand_value);
                  default: hit = $signed(column_mirror[i]) < $signed(beat.operand_value);
               endcase
               if (hit) hits++;
            end
            answer.match_count = (hits > COUNT_MAX) ? COUNT_MAX : COUNT_W'(hits);
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   // Operands lean toward values already in the column, so that equality counts and
   // ties in the ordered counts happen often, and toward the extremes of the range.
   function automatic logic signed [VALUE_W-1:0] pick_operand();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 30 && mirror_fill != 0) return column_mirror[$urandom_range(mirror_fill - 1)];
      if (roll < 45) return EDGE_VALUES[$urandom_range(4)];
      if (roll < 70) return int'($urandom_range(16)) - 8;
      return $signed($urandom());
   endfunction

   // Mostly appends, in-range reads and counts, with some out-of-range reads and unused
   // commands mixed in. Position bits are random on every beat except most reads.
   function automatic req_type random_beat();
      req_type     beat;
      int unsigned roll;
      beat.operand_value = pick_operand();
      beat.position      = POS_W'($urandom_range(DEPTH - 1));
      roll = $urandom_range(99);
      if (roll < 40) begin
         beat.command = CMD_APPEND;
      end else if (roll < 60) begin
         beat.command = CMD_READ;
         if (mirror_fill != 0 && $urandom_range(99) < 80) begin
            beat.position = POS_W'($urandom_range(mirror_fill - 1));
         end else if (mirror_fill < DEPTH && $urandom_range(1) == 0) begin
            beat.position = POS_W'(mirror_fill);
         end
      end else if (roll < 72) begin
         beat.command = CMD_EQ;
      end else if (roll < 84) begin
         beat.command = CMD_GT;
      end else if (roll < 96) begin
         beat.command = CMD_LT;
      end else begin
         beat.command = SPARE_CODES[$urandom_range(2)];
      end
      return beat;
   endfunction

   // Offers one request beat, after a random idle gap, and books its response at the
   // edge where it is accepted. Valid is only lowered when a gap is actually taken, so
   // back-to-back beats never see valid dropped and raised in the same time step.
   task automatic send_beat(input req_type beat, input bit fixed, input rsp_type want);
      rsp_type answer;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      answer = column_answer(beat);
      pending_answers.push_back(fixed ? want : answer);
   endtask

   // Stops offering beats and waits until every booked response has come back.
   task automatic drain_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // The receiver accepts response beats and checks each against the oldest booked
   // response. Ready is drawn anew every cycle, independent of valid, and is held low
   // for the whole hold-off stretch.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected response beat: status %0d value %0d count %0d",
                           rsp_data.status, rsp_data.read_value, rsp_data.match_count);
               end
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.status !== want.status || rsp_data.read_value !== want.read_value ||
                   rsp_data.match_count !== want.match_count) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("response mismatch: expected status %0d value %0d count %0d",
                              want.status, want.read_value, want.match_count);
                     $display("                   got status %0d value %0d count %0d",
                              rsp_data.status, rsp_data.read_value, rsp_data.match_count);
                  end
               end
            end
         end
         rsp_ready <= !receiver_held && ($urandom_range(99) >= stall_pct);
      end
   end

   // Long receiver hold-off, counted here in clock cycles. While it lasts the sender keeps
   // offering beats, so the block has to hold its response and stall its input.
   initial begin
      forever begin
         @(hold_off_start);
         receiver_held <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         receiver_held <= 1'b0;
      end
   end

   // Stimulus and end of run.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i]) begin
         send_beat(probe_rows[i].beat, probe_rows[i].fixed, probe_rows[i].want);
      end
      drain_answers();

      // Random beats in each idling phase. The first phase opens with the long hold-off,
      // and every phase ends with the sender pausing until all responses are back.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = SEND_IDLE[phase];
         stall_pct     = RECV_STALL[phase];
         if (phase == 0) -> hold_off_start;
         repeat (RANDOM_BEATS) send_beat(random_beat(), 1'b0, RSP_DONE);
         drain_answers();
      end

      // Any stray response beat after this point is caught by the receiver.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
